// ===== hw/rtl/rcw_pkg.sv =====
package rcw_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLAYER_X = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLAYER_Y = 8'd1;

    // Smallest perpendicular distance, 0.1 in Q16.16 rounded to nearest.
    localparam logic [31:0] PERP_MIN   = 32'd6554;
    localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;
    localparam logic [27:0] Q28_MAX    = 28'hFFFFFFF;

    // Texture step divider: texture height in Q13.16 over the wall height.
    localparam int STEP_NUM_W = 29;
    localparam int STEP_DEN_W = 20;

    typedef struct packed {
        logic [11:0]        column;
        logic               hit_side;
        logic [31:0]        acc_dist_x;
        logic [31:0]        acc_dist_y;
        logic [31:0]        cell_step_x;
        logic [31:0]        cell_step_y;
        logic signed [20:0] ray_dx;
        logic signed [20:0] ray_dy;
        logic [12:0]        tex_width;
        logic [12:0]        tex_height;
    } in_item_t;

    // Column data once the texture column is known.
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] texel_column;
        logic [12:0] tex_height;
        logic [31:0] perp;
    } front_t;

    // Column data once the rows are known.
    typedef struct packed {
        logic [11:0] column;
        logic [19:0] wall_height;
        logic [9:0]  draw_start;
        logic [9:0]  draw_end;
        logic [11:0] texel_column;
        logic [19:0] t2;
    } row_t;

    typedef struct packed {
        logic [27:0] texel_start;
        logic [27:0] texel_step;
        logic [11:0] texel_column;
        logic [9:0]  draw_end;
        logic [9:0]  draw_start;
        logic [19:0] wall_height;
        logic [11:0] out_column;
    } out_item_t;

endpackage

// ===== hw/rtl/rcw_div.sv =====
module rcw_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 32,
    parameter int PAY_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [NUM_W-1:0] out_quo,
    output logic [PAY_W-1:0] out_pay
);

    // One quotient bit per stage, most significant first.
    logic             v_reg   [0:NUM_W-1];
    logic [DEN_W-1:0] rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0] quo_reg [0:NUM_W-1];
    logic [NUM_W-1:0] num_reg [0:NUM_W-1];
    logic [DEN_W-1:0] den_reg [0:NUM_W-1];
    logic [PAY_W-1:0] pay_reg [0:NUM_W-1];
    logic             rdy     [0:NUM_W];

    assign rdy[NUM_W] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[NUM_W-1];
    assign out_quo    = quo_reg[NUM_W-1];
    assign out_pay    = pay_reg[NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             p_v;
        logic [DEN_W-1:0] p_rem;
        logic [NUM_W-1:0] p_quo;
        logic [NUM_W-1:0] p_num;
        logic [DEN_W-1:0] p_den;
        logic [PAY_W-1:0] p_pay;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign p_v   = in_valid;
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_num = in_num;
            assign p_den = in_den;
            assign p_pay = in_pay;
        end else begin : g_next
            assign p_v   = v_reg[k-1];
            assign p_rem = rem_reg[k-1];
            assign p_quo = quo_reg[k-1];
            assign p_num = num_reg[k-1];
            assign p_den = den_reg[k-1];
            assign p_pay = pay_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            trial    = {p_rem, p_num[NUM_W-1-k]};
            diff     = trial - {1'b0, p_den};
            ge       = (trial >= {1'b0, p_den});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = p_quo;
            quo_next[NUM_W-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                num_reg[k] <= p_num;
                den_reg[k] <= p_den;
                pay_reg[k] <= p_pay;
            end
        end
    end

endmodule

// ===== hw/rtl/rcw_front.sv =====
module rcw_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      player_x,
    input  logic [31:0]      player_y,
    input  logic             in_valid,
    output logic             in_ready,
    input  rcw_pkg::in_item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output rcw_pkg::front_t  out_item
);

    typedef struct packed {
        logic [11:0] column;
        logic        mirror;
        logic [15:0] base16;
        logic [31:0] dir;
        logic [31:0] perp;
        logic [12:0] tw;
        logic [12:0] th;
    } f1_t;

    typedef struct packed {
        logic [11:0] column;
        logic        mirror;
        logic [31:0] frac;
        logic [31:0] perp;
        logic [12:0] tw;
        logic [12:0] th;
    } f3_t;

    typedef struct packed {
        logic [11:0] column;
        logic        mirror;
        logic [12:0] txp;
        logic [31:0] perp;
        logic [12:0] tw;
        logic [12:0] th;
    } f4_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    f1_t  s1_reg, s1_next;
    f1_t  s2_reg;
    logic [31:0] prod_reg;
    f3_t  s3_reg, s3_next;
    f4_t  s4_reg, s4_next;

    logic signed [32:0] diff;
    logic [63:0]        prod_w;
    logic [44:0]        tex_w;
    logic               dx_pos;
    logic               dy_neg;
    logic [11:0]        tx;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: perpendicular distance, hit axis and mirror decision.
    always_comb begin
        if (in_item.hit_side) begin
            diff = $signed({1'b0, in_item.acc_dist_y}) - $signed({1'b0, in_item.cell_step_y});
        end else begin
            diff = $signed({1'b0, in_item.acc_dist_x}) - $signed({1'b0, in_item.cell_step_x});
        end
        dx_pos = !in_item.ray_dx[20] && (in_item.ray_dx != '0);
        dy_neg = in_item.ray_dy[20];
        s1_next.column = in_item.column;
        s1_next.perp   = (diff <= 0) ? rcw_pkg::PERP_MIN : diff[31:0];
        s1_next.mirror = (!in_item.hit_side && dx_pos) || (in_item.hit_side && dy_neg);
        s1_next.base16 = in_item.hit_side ? player_x[15:0] : player_y[15:0];
        s1_next.dir    = in_item.hit_side ? {{11{in_item.ray_dx[20]}}, in_item.ray_dx}
                                          : {{11{in_item.ray_dy[20]}}, in_item.ray_dy};
        s1_next.tw     = in_item.tex_width;
        s1_next.th     = in_item.tex_height;
    end

    // Stage 2 multiplies, stage 3 adds the position, stage 4 scales by width.
    assign prod_w = s1_reg.perp * s1_reg.dir;

    always_comb begin
        s3_next.column = s2_reg.column;
        s3_next.mirror = s2_reg.mirror;
        s3_next.frac   = {s2_reg.base16, 16'd0} + prod_reg;
        s3_next.perp   = s2_reg.perp;
        s3_next.tw     = s2_reg.tw;
        s3_next.th     = s2_reg.th;
    end

    assign tex_w = s3_reg.frac * s3_reg.tw;

    always_comb begin
        s4_next.column = s3_reg.column;
        s4_next.mirror = s3_reg.mirror;
        s4_next.txp    = tex_w[44:32];
        s4_next.perp   = s3_reg.perp;
        s4_next.tw     = s3_reg.tw;
        s4_next.th     = s3_reg.th;
    end

    // Mirroring wraps within twelve bits.
    assign tx = s4_reg.mirror ? (s4_reg.tw[11:0] - s4_reg.txp[11:0] - 12'd1)
                              : s4_reg.txp[11:0];

    always_comb begin
        out_item.column       = s4_reg.column;
        out_item.texel_column = tx;
        out_item.tex_height   = s4_reg.th;
        out_item.perp         = s4_reg.perp;
    end
    assign out_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2) begin
            s2_reg   <= s1_reg;
            prod_reg <= prod_w[31:0];
        end
        if (rdy3) s3_reg <= s3_next;
        if (rdy4) s4_reg <= s4_next;
    end

endmodule

// ===== hw/rtl/rcw_rows.sv =====
module rcw_rows #(
    parameter int SCREEN_HEIGHT = 1024,
    parameter int QUO_W = 29
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [QUO_W-1:0] in_quo,
    input  rcw_pkg::front_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output rcw_pkg::row_t    out_item,
    output logic [12:0]      out_tex_height
);

    localparam int HALF     = SCREEN_HEIGHT / 2;
    localparam int TWO_HALF = 2 * HALF;

    logic          v_reg;
    rcw_pkg::row_t row_reg, row_next;
    logic [12:0]   th_reg;
    logic [19:0]   h;
    logic [20:0]   h21;
    logic [20:0]   start_w;
    logic [20:0]   end_w;
    logic [20:0]   t2_w;

    always_comb begin
        h   = (|in_quo[QUO_W-1:20]) ? rcw_pkg::HEIGHT_MAX : in_quo[19:0];
        h21 = {1'b0, h};
        start_w = '0;
        if (h21 < 21'(TWO_HALF)) begin
            start_w = (21'(TWO_HALF) - h21) >> 1;
        end
        end_w = 21'(HALF) + (h21 >> 1);
        if (end_w >= 21'(SCREEN_HEIGHT)) begin
            end_w = 21'(SCREEN_HEIGHT - 1);
        end
        // The texture start is only non-zero once the wall overflows the screen.
        t2_w = (h21 > 21'(TWO_HALF)) ? (h21 - 21'(TWO_HALF)) : '0;
        row_next.column       = in_item.column;
        row_next.wall_height  = h;
        row_next.draw_start   = start_w[9:0];
        row_next.draw_end     = end_w[9:0];
        row_next.texel_column = in_item.texel_column;
        row_next.t2           = t2_w[19:0];
    end

    assign in_ready       = !v_reg || out_ready;
    assign out_valid      = v_reg;
    assign out_item       = row_reg;
    assign out_tex_height = th_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            row_reg <= row_next;
            th_reg  <= in_item.tex_height;
        end
    end

endmodule

// ===== hw/rtl/rcw_tail.sv =====
module rcw_tail (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rcw_pkg::STEP_NUM_W-1:0]    in_quo,
    input  rcw_pkg::row_t                     in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rcw_pkg::out_item_t                out_item
);

    logic               v1_reg, v2_reg;
    logic               rdy1, rdy2;
    rcw_pkg::row_t      row_reg;
    logic [27:0]        step_reg;
    logic [47:0]        prod_reg;
    rcw_pkg::out_item_t out_reg, out_next;
    logic [27:0]        step;
    logic [47:0]        prod_w;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // A zero wall height divides by zero, which yields all ones and saturates.
    assign step   = in_quo[28] ? rcw_pkg::Q28_MAX : in_quo[27:0];
    assign prod_w = in_item.t2 * step;

    always_comb begin
        out_next.out_column   = row_reg.column;
        out_next.wall_height  = row_reg.wall_height;
        out_next.draw_start   = row_reg.draw_start;
        out_next.draw_end     = row_reg.draw_end;
        out_next.texel_column = row_reg.texel_column;
        out_next.texel_step   = step_reg;
        out_next.texel_start  = (|prod_reg[47:29]) ? rcw_pkg::Q28_MAX : prod_reg[28:1];
    end

    assign out_valid = v2_reg;
    assign out_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            row_reg  <= in_item;
            step_reg <= step;
            prod_reg <= prod_w;
        end
        if (rdy2) out_reg <= out_next;
    end

endmodule

// ===== hw/rtl/raycast_wall_column_setup_top.sv =====
// Channel     | Direction | Handshake              | Payload
// ------------+-----------+------------------------+-------------------------------------
// s_ (column) | in        | s_tvalid / s_tready    | s_tdata 208 bits, s_tuser hit side
// m_ (result) | out       | m_tvalid / m_tready    | m_tdata 120 bits
// cfg_        | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data 32 bits
//
// One column is taken in every cycle while m_tready does not stall the pipeline. A column
// passes through the front stages, the height divider, the row stage, the step divider
// and the tail stages in order; the two bit-per-stage dividers hold most of the stages.
// Reset is synchronous and active low; it empties every stage and clears both player
// registers. Each stage holds its contents only while it is full and its successor cannot
// take a transfer, so bubbles close up and a stalled result never blocks earlier stages
// that still have room.
module raycast_wall_column_setup_top #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // column, acc_dist_x, acc_dist_y, cell_step_x, cell_step_y, ray_dx, ray_dy,
    // tex_width, tex_height (from bit 0 upwards)
    input  logic [207:0] s_tdata,
    // hit_side
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_column, wall_height, draw_start, draw_end, texel_column, texel_step,
    // texel_start (from bit 0 upwards)
    output logic [119:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [rcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);

    // The height divider numerator is the screen height with 16 fraction bits, Q11.16 at the default screen height.
    localparam int H_NUM_W = $clog2(SCREEN_HEIGHT + 1) + 16;

    logic [31:0] player_x_reg;
    logic [31:0] player_y_reg;

    rcw_pkg::in_item_t  in_item;
    rcw_pkg::front_t    front_item, div1_item;
    rcw_pkg::row_t      row_item, div2_item;
    rcw_pkg::out_item_t out_item;
    logic [12:0]        row_th;

    logic front_valid, front_ready;
    logic div1_valid, div1_ready;
    logic row_valid, row_ready;
    logic div2_valid, div2_ready;
    logic [H_NUM_W-1:0]             h_quo;
    logic [rcw_pkg::STEP_NUM_W-1:0] step_quo;
    logic [$bits(rcw_pkg::front_t)-1:0] div1_pay;
    logic [$bits(rcw_pkg::row_t)-1:0]   div2_pay;

    // The user must write configuration only while the pipeline is idle (not enforced); writes always complete.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_x_reg <= '0;
            player_y_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rcw_pkg::CFG_PLAYER_X: player_x_reg <= cfg_data;
                rcw_pkg::CFG_PLAYER_Y: player_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.column      = s_tdata[11:0];
        in_item.hit_side    = s_tuser;
        in_item.acc_dist_x  = s_tdata[43:12];
        in_item.acc_dist_y  = s_tdata[75:44];
        in_item.cell_step_x = s_tdata[107:76];
        in_item.cell_step_y = s_tdata[139:108];
        in_item.ray_dx      = s_tdata[160:140];
        in_item.ray_dy      = s_tdata[181:161];
        in_item.tex_width   = s_tdata[194:182];
        in_item.tex_height  = s_tdata[207:195];
    end

    // Distance, wall hit position and texture column.
    rcw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .player_x  (player_x_reg),
        .player_y  (player_y_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // Wall height: screen height over the perpendicular distance.
    rcw_div #(
        .NUM_W (H_NUM_W),
        .DEN_W (32),
        .PAY_W ($bits(rcw_pkg::front_t))
    ) u_height_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_num    (H_NUM_W'(SCREEN_HEIGHT) << 16),
        .in_den    (front_item.perp),
        .in_pay    (front_item),
        .out_valid (div1_valid),
        .out_ready (div1_ready),
        .out_quo   (h_quo),
        .out_pay   (div1_pay)
    );

    assign div1_item = rcw_pkg::front_t'(div1_pay);

    rcw_rows #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .QUO_W         (H_NUM_W)
    ) u_rows (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (div1_valid),
        .in_ready       (div1_ready),
        .in_quo         (h_quo),
        .in_item        (div1_item),
        .out_valid      (row_valid),
        .out_ready      (row_ready),
        .out_item       (row_item),
        .out_tex_height (row_th)
    );

    // Texture step: texture height in Q13.16 over the wall height.
    rcw_div #(
        .NUM_W (rcw_pkg::STEP_NUM_W),
        .DEN_W (rcw_pkg::STEP_DEN_W),
        .PAY_W ($bits(rcw_pkg::row_t))
    ) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (row_valid),
        .in_ready  (row_ready),
        .in_num    ({row_th, 16'd0}),
        .in_den    (row_item.wall_height),
        .in_pay    (row_item),
        .out_valid (div2_valid),
        .out_ready (div2_ready),
        .out_quo   (step_quo),
        .out_pay   (div2_pay)
    );

    assign div2_item = rcw_pkg::row_t'(div2_pay);

    // Texture start position and the output register.
    rcw_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div2_valid),
        .in_ready  (div2_ready),
        .in_quo    (step_quo),
        .in_item   (div2_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item;

    // A wall of zero height has the saturated texture step.
    a_zero_height_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_item.wall_height == '0) |-> out_item.texel_step == rcw_pkg::Q28_MAX)
        else $error("zero wall height without saturated texture step");

    // A non-zero texture start only occurs when the wall covers the top row.
    a_start_top_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_item.texel_start != '0) |-> out_item.draw_start == '0)
        else $error("texture start offset with wall below the top row");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result presented right after reset");

endmodule
